/* hdl/bmf_pkg.sv */
// bmf_pkg: shared constants and types for the Bezier midpoint flattener.
// No dependencies; imported by the top level and the subdivision stack.
package bmf_pkg;

   localparam int QUAD_DEPTH_DEF  = 3;
   localparam int CUBIC_DEPTH_DEF = 4;
   localparam int COORD_WIDTH_DEF = 24;

   // segment kind carried by req_action
   localparam logic ACTION_QUAD  = 1'b0;
   localparam logic ACTION_CUBIC = 1'b1;

   // stack control from the sequencer
   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

/* hdl/bmf_midpoint.sv */
// bmf_midpoint: shared midpoint unit, (a + b) / 2 truncated toward zero, x and y.
// Standalone; used by bezier_midpoint_flattener_top.
module bmf_midpoint #(
   parameter int COORD_WIDTH = 24
) (
   input  logic signed [COORD_WIDTH-1:0] a_x,
   input  logic signed [COORD_WIDTH-1:0] a_y,
   input  logic signed [COORD_WIDTH-1:0] b_x,
   input  logic signed [COORD_WIDTH-1:0] b_y,
   output logic signed [COORD_WIDTH-1:0] m_x,
   output logic signed [COORD_WIDTH-1:0] m_y
);

   logic [COORD_WIDTH:0] sum_x, sum_y;
   logic [COORD_WIDTH:0] adj_x, adj_y;

   always_comb begin
      sum_x = {a_x[COORD_WIDTH-1], a_x} + {b_x[COORD_WIDTH-1], b_x};
      sum_y = {a_y[COORD_WIDTH-1], a_y} + {b_y[COORD_WIDTH-1], b_y};
      // negative sums get +1 so the arithmetic shift rounds toward zero
      adj_x = sum_x + {{COORD_WIDTH{1'b0}}, sum_x[COORD_WIDTH]};
      adj_y = sum_y + {{COORD_WIDTH{1'b0}}, sum_y[COORD_WIDTH]};
   end

   assign m_x = adj_x[COORD_WIDTH:1];
   assign m_y = adj_y[COORD_WIDTH:1];

endmodule

/* hdl/bmf_stack.sv */
// bmf_stack: LIFO of pending right-half sub-curves (control points + level).
// Depends on bmf_pkg (stack_ctl_type).
module bmf_stack #(
   parameter int DEPTH       = 4,
   parameter int ENTRY_WIDTH = 200
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bmf_pkg::stack_ctl_type     ctl,
   input  logic [ENTRY_WIDTH-1:0]     wr_data,
   output logic [ENTRY_WIDTH-1:0]     rd_data,
   output logic                       empty
);
   import bmf_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ENTRY_WIDTH-1:0] mem_ff [DEPTH];
   logic [CNT_W-1:0]       sp_ff, sp_in;
   logic [CNT_W-1:0]       top_cnt;
   logic [CNT_W-1:0]       wr_cnt;

   always_comb begin
      top_cnt = sp_ff - CNT_W'(1);
      wr_cnt  = sp_ff;
      sp_in   = sp_ff;
      if (ctl.push) begin
         sp_in = sp_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         sp_in = top_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_cnt[IDX_W-1:0]] <= wr_data;
      end
   end

   assign rd_data = mem_ff[top_cnt[IDX_W-1:0]];
   assign empty   = (sp_ff == '0);

endmodule

/* hdl/bezier_midpoint_flattener_top.sv */
// Bezier midpoint flattener: depth-first de Casteljau subdivision, one midpoint per SPLIT cycle.
// A split node computes ab, bc, cd, abc, bcd, mid (cubic) or ab, bc, abc (quadratic) in order;
// a leaf emits its end point and then resumes with the next stacked right half, if there is one.
// start is taken only while idle, so a new request waits until the previous one is done.
// busy stays high until the last point is registered; the receiver cannot stall.
// Synchronous active-high reset returns to idle and drops the strobe; no state is kept.
module bezier_midpoint_flattener_top #(
   parameter int QUAD_DEPTH  = bmf_pkg::QUAD_DEPTH_DEF,
   parameter int CUBIC_DEPTH = bmf_pkg::CUBIC_DEPTH_DEF,
   parameter int COORD_WIDTH = bmf_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic signed [COORD_WIDTH-1:0] req_p0_x,
   input  logic signed [COORD_WIDTH-1:0] req_p0_y,
   input  logic signed [COORD_WIDTH-1:0] req_p1_x,
   input  logic signed [COORD_WIDTH-1:0] req_p1_y,
   input  logic signed [COORD_WIDTH-1:0] req_p2_x,
   input  logic signed [COORD_WIDTH-1:0] req_p2_y,
   input  logic signed [COORD_WIDTH-1:0] req_p3_x,
   input  logic signed [COORD_WIDTH-1:0] req_p3_y,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_point_x,
   output logic signed [COORD_WIDTH-1:0] rsp_point_y,
   output logic                          rsp_last
);
   import bmf_pkg::*;

   localparam int W           = COORD_WIDTH;
   localparam int MAX_DEPTH   = (QUAD_DEPTH > CUBIC_DEPTH) ? QUAD_DEPTH : CUBIC_DEPTH;
   localparam int STACK_DEPTH = (MAX_DEPTH > 0) ? MAX_DEPTH : 1;
   localparam int LVL_W       = (MAX_DEPTH > 0) ? $clog2(MAX_DEPTH + 1) : 1;
   localparam int ENTRY_W     = 8 * W + LVL_W;

   typedef enum logic [1:0] {IDLE, SPLIT, LEAF} state_type;
   typedef enum logic [2:0] {ST_AB, ST_BC, ST_CD, ST_ABC, ST_BCD, ST_MID} step_type;

   state_type          state_ff, state_in;
   step_type           step_ff, step_in;
   logic               cubic_ff, cubic_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic signed [W-1:0] cx_ff [4];
   logic signed [W-1:0] cy_ff [4];
   logic signed [W-1:0] cx_in [4];
   logic signed [W-1:0] cy_in [4];
   logic signed [W-1:0] ab_x_ff, ab_y_ff, ab_x_in, ab_y_in;
   logic signed [W-1:0] bc_x_ff, bc_y_ff, bc_x_in, bc_y_in;
   logic signed [W-1:0] cd_x_ff, cd_y_ff, cd_x_in, cd_y_in;
   logic signed [W-1:0] abc_x_ff, abc_y_ff, abc_x_in, abc_y_in;
   logic signed [W-1:0] bcd_x_ff, bcd_y_ff, bcd_x_in, bcd_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_last_ff, rsp_last_in;
   logic signed [W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic signed [W-1:0] op_a_x, op_a_y, op_b_x, op_b_y, mid_x, mid_y;
   stack_ctl_type       stk_ctl;
   logic [ENTRY_W-1:0]  stk_wr, stk_rd;
   logic                stk_empty;
   logic                split_done;
   logic [LVL_W-1:0]    start_lvl, lvl_dec, pop_lvl;

   bmf_midpoint #(.COORD_WIDTH(W)) u_mid (
      .a_x(op_a_x), .a_y(op_a_y), .b_x(op_b_x), .b_y(op_b_y),
      .m_x(mid_x), .m_y(mid_y)
   );

   bmf_stack #(.DEPTH(STACK_DEPTH), .ENTRY_WIDTH(ENTRY_W)) u_stack (
      .clock(clock), .reset(reset), .ctl(stk_ctl),
      .wr_data(stk_wr), .rd_data(stk_rd), .empty(stk_empty)
   );

   // operand select for the shared midpoint unit
   always_comb begin
      op_a_x = cx_ff[0];
      op_a_y = cy_ff[0];
      op_b_x = cx_ff[1];
      op_b_y = cy_ff[1];
      unique case (step_ff)
         ST_AB: begin
            op_a_x = cx_ff[0]; op_a_y = cy_ff[0];
            op_b_x = cx_ff[1]; op_b_y = cy_ff[1];
         end
         ST_BC: begin
            op_a_x = cx_ff[1]; op_a_y = cy_ff[1];
            op_b_x = cx_ff[2]; op_b_y = cy_ff[2];
         end
         ST_CD: begin
            op_a_x = cx_ff[2]; op_a_y = cy_ff[2];
            op_b_x = cx_ff[3]; op_b_y = cy_ff[3];
         end
         ST_ABC: begin
            op_a_x = ab_x_ff; op_a_y = ab_y_ff;
            op_b_x = bc_x_ff; op_b_y = bc_y_ff;
         end
         ST_BCD: begin
            op_a_x = bc_x_ff; op_a_y = bc_y_ff;
            op_b_x = cd_x_ff; op_b_y = cd_y_ff;
         end
         ST_MID: begin
            op_a_x = abc_x_ff; op_a_y = abc_y_ff;
            op_b_x = bcd_x_ff; op_b_y = bcd_y_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      start_lvl = (req_action == ACTION_CUBIC) ? LVL_W'(CUBIC_DEPTH) : LVL_W'(QUAD_DEPTH);
      lvl_dec   = lvl_ff - LVL_W'(1);
      pop_lvl   = stk_rd[8*W +: LVL_W];
      // right half of the split: cubic (mid, bcd, cd, d), quadratic (abc, bc, c)
      if (cubic_ff) begin
         stk_wr = {lvl_dec, cy_ff[3], cx_ff[3], cd_y_ff, cd_x_ff,
                   bcd_y_ff, bcd_x_ff, mid_y, mid_x};
      end else begin
         stk_wr = {lvl_dec, cy_ff[3], cx_ff[3], cy_ff[2], cx_ff[2],
                   bc_y_ff, bc_x_ff, mid_y, mid_x};
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cubic_in = cubic_ff;
      lvl_in   = lvl_ff;
      for (int i = 0; i < 4; i++) begin
         cx_in[i] = cx_ff[i];
         cy_in[i] = cy_ff[i];
      end
      ab_x_in  = ab_x_ff;  ab_y_in  = ab_y_ff;
      bc_x_in  = bc_x_ff;  bc_y_in  = bc_y_ff;
      cd_x_in  = cd_x_ff;  cd_y_in  = cd_y_ff;
      abc_x_in = abc_x_ff; abc_y_in = abc_y_ff;
      bcd_x_in = bcd_x_ff; bcd_y_in = bcd_y_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      stk_ctl      = '0;
      split_done   = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cx_in[0] = req_p0_x; cy_in[0] = req_p0_y;
               cx_in[1] = req_p1_x; cy_in[1] = req_p1_y;
               cx_in[2] = req_p2_x; cy_in[2] = req_p2_y;
               cx_in[3] = req_p3_x; cy_in[3] = req_p3_y;
               cubic_in = (req_action == ACTION_CUBIC);
               lvl_in   = start_lvl;
               step_in  = ST_AB;
               state_in = (start_lvl == '0) ? LEAF : SPLIT;
            end
         end
         SPLIT: begin
            unique case (step_ff)
               ST_AB: begin
                  ab_x_in = mid_x; ab_y_in = mid_y;
                  step_in = ST_BC;
               end
               ST_BC: begin
                  bc_x_in = mid_x; bc_y_in = mid_y;
                  step_in = cubic_ff ? ST_CD : ST_ABC;
               end
               ST_CD: begin
                  cd_x_in = mid_x; cd_y_in = mid_y;
                  step_in = ST_ABC;
               end
               ST_ABC: begin
                  abc_x_in = mid_x; abc_y_in = mid_y;
                  if (cubic_ff) begin
                     step_in = ST_BCD;
                  end else begin
                     split_done = 1'b1;
                  end
               end
               ST_BCD: begin
                  bcd_x_in = mid_x; bcd_y_in = mid_y;
                  step_in  = ST_MID;
               end
               ST_MID: begin
                  split_done = 1'b1;
               end
               default: begin
               end
            endcase
            if (split_done) begin
               // keep the left half as the current curve, stack the right half
               stk_ctl.push = 1'b1;
               cx_in[1] = ab_x_ff; cy_in[1] = ab_y_ff;
               if (cubic_ff) begin
                  cx_in[2] = abc_x_ff; cy_in[2] = abc_y_ff;
                  cx_in[3] = mid_x;    cy_in[3] = mid_y;
               end else begin
                  cx_in[2] = mid_x;    cy_in[2] = mid_y;
               end
               lvl_in   = lvl_dec;
               step_in  = ST_AB;
               state_in = (lvl_dec == '0) ? LEAF : SPLIT;
            end
         end
         LEAF: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = stk_empty;
            rsp_x_in     = cubic_ff ? cx_ff[3] : cx_ff[2];
            rsp_y_in     = cubic_ff ? cy_ff[3] : cy_ff[2];
            if (stk_empty) begin
               state_in = IDLE;
            end else begin
               stk_ctl.pop = 1'b1;
               for (int i = 0; i < 4; i++) begin
                  cx_in[i] = stk_rd[(2*i)*W +: W];
                  cy_in[i] = stk_rd[(2*i+1)*W +: W];
               end
               lvl_in   = pop_lvl;
               step_in  = ST_AB;
               state_in = (pop_lvl == '0) ? LEAF : SPLIT;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
      step_ff  <= step_in;
      cubic_ff <= cubic_in;
      lvl_ff   <= lvl_in;
      for (int i = 0; i < 4; i++) begin
         cx_ff[i] <= cx_in[i];
         cy_ff[i] <= cy_in[i];
      end
      ab_x_ff  <= ab_x_in;  ab_y_ff  <= ab_y_in;
      bc_x_ff  <= bc_x_in;  bc_y_ff  <= bc_y_in;
      cd_x_ff  <= cd_x_in;  cd_y_ff  <= cd_y_in;
      abc_x_ff <= abc_x_in; abc_y_ff <= abc_y_in;
      bcd_x_ff <= bcd_x_in; bcd_y_ff <= bcd_y_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign busy        = (state_ff != IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;

endmodule

/* hdl/bmf_checker.sv */
// bmf_checker: port-level checks on busy and the point strobe over time.
// Bound to bezier_midpoint_flattener_top; no package dependency.
module bmf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last
);

   // an accepted request keeps the block busy on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted request");

   // busy only drops together with the final point of a run
   a_fell_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_last)
      else $error("busy fell without a final point");

   // more points follow a non-final point, so the block is still working
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final point while idle");

   // a new run cannot deliver a point right after the previous run ended
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("point strobe directly after a final point");

endmodule

bind bezier_midpoint_flattener_top bmf_checker u_bmf_checker (.*);
